// ===== rtl/primitive_root_search_defines.svh =====
// Assertion macros used by the RTL controller of the primitive root search block.
`ifndef PRIMITIVE_ROOT_SEARCH_DEFINES_SVH
`define PRIMITIVE_ROOT_SEARCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prs assertion failed");

// Next-cycle implication, checked outside reset.
`define PRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prs assertion failed");

`endif

// ===== rtl/prs_pkg.sv =====
package prs_pkg;

  localparam int unsigned PRS_WIDTH = 16;
  localparam int unsigned FIELD_W   = 16;

  typedef struct packed {
    logic load;
    logic cand_init;
    logic cand_next;
    logic mul_start;
    logic mul_step;
    logic out_load;
    logic out_found;
  } prs_cmd_t;

  typedef struct packed {
    logic trivial;
    logic bit_last;
    logic x_is_one;
    logic k_at_n;
    logic c_last;
  } prs_status_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INIT  = 6'b000010,
    S_CAND  = 6'b000100,
    S_MUL   = 6'b001000,
    S_CHECK = 6'b010000,
    S_DONE  = 6'b100000
  } prs_state_t;

endpackage

// ===== rtl/primitive_root_search.sv =====
// Primitive root search.
// Input channel (in_valid/in_ready) takes one beat of order_prime p and
// modulus m. Output channel (out_valid/out_ready) returns one beat per input:
// root is the smallest c in 2..p-1 whose power chain mod m first reaches one
// at exponent p-1, with found set; otherwise root is 1 and found is clear.
// Inputs are taken at WIDTH bits; p <= 2 or m <= 1 answers at once.
// One item is worked at a time. Each modular multiply runs in the shift-add
// reduction unit in state S_MUL, set up by S_CAND and followed by S_CHECK,
// and a candidate stops at the first power equal to one.
// in_ready is high only while no item is in work. The result sits in an
// output register; if the receiver stalls, a finished search waits until that
// register is free, and the next beat may be taken while it still holds.
// Synchronous reset (rst_n low) drops any search in work and any pending
// result.
module primitive_root_search #(
  parameter int unsigned WIDTH = prs_pkg::PRS_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [prs_pkg::FIELD_W-1:0] in_order_prime,
  input  logic [prs_pkg::FIELD_W-1:0] in_modulus,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [prs_pkg::FIELD_W-1:0] out_root,
  output logic                        out_found
);
  import prs_pkg::*;

  prs_cmd_t    cmd;
  prs_status_t status;

  prs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  prs_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk            (clk),
    .in_order_prime (in_order_prime),
    .in_modulus     (in_modulus),
    .out_root       (out_root),
    .out_found      (out_found),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

// ===== rtl/prs_ctrl.sv =====
`include "primitive_root_search_defines.svh"

module prs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output prs_pkg::prs_cmd_t    cmd,
  input  prs_pkg::prs_status_t status
);
  import prs_pkg::*;

  prs_state_t state_r, state_nxt;
  logic       found_r, found_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    found_nxt = found_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        if (status.trivial) begin
          found_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          cmd.cand_init = 1'b1;
          state_nxt     = S_CAND;
        end
      end
      S_CAND: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (status.bit_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // A power of one before the last exponent, or a last power other than
        // one, rejects the candidate.
        priority if (status.k_at_n && status.x_is_one) begin
          found_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (status.k_at_n || status.x_is_one) begin
          if (status.c_last) begin
            found_nxt = 1'b0;
            state_nxt = S_DONE;
          end else begin
            cmd.cand_next = 1'b1;
            state_nxt     = S_CAND;
          end
        end else begin
          state_nxt = S_CAND;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          cmd.out_found = found_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `PRS_ASSERT_NEXT(a_accept_to_init, clk, rst_n, in_valid && in_ready, state_r == S_INIT)
  `PRS_ASSERT_NEXT(a_done_delivers, clk, rst_n, cmd.out_load, out_valid && state_r == S_IDLE)
  `PRS_ASSERT_NEXT(a_mul_to_check, clk, rst_n, state_r == S_MUL && status.bit_last,
                   state_r == S_CHECK)
  `PRS_ASSERT_NOW(a_no_step_past_end, clk, rst_n, cmd.cand_next, !status.c_last)

endmodule

// ===== rtl/prs_datapath.sv =====
module prs_datapath #(
  parameter int unsigned WIDTH = prs_pkg::PRS_WIDTH
) (
  input  logic                          clk,
  input  logic [prs_pkg::FIELD_W-1:0]   in_order_prime,
  input  logic [prs_pkg::FIELD_W-1:0]   in_modulus,
  output logic [prs_pkg::FIELD_W-1:0]   out_root,
  output logic                          out_found,
  input  prs_pkg::prs_cmd_t             cmd,
  output prs_pkg::prs_status_t          status
);
  import prs_pkg::*;

  localparam int unsigned BW = $clog2(WIDTH);

  logic [WIDTH-1:0]   p_r, m_r, c_r, r_r, x_r, k_r, acc_r;
  logic [BW-1:0]      b_r;
  logic [FIELD_W-1:0] root_r;
  logic               found_r;

  logic [WIDTH-1:0]   r_init, r_inc, r_next;
  logic [WIDTH+1:0]   t, m1, m2, t_red;

  assign r_init = (m_r == WIDTH'(2)) ? '0 : WIDTH'(2);
  assign r_inc  = r_r + WIDTH'(1);
  assign r_next = (r_inc == m_r) ? '0 : r_inc;

  // Interleaved modular multiply: multiplier bits of r, MSB first.
  // acc and x stay below m, so t stays below three times m.
  assign m1 = (WIDTH+2)'(m_r);
  assign m2 = {1'b0, m_r, 1'b0};
  assign t  = {1'b0, acc_r, 1'b0} + (r_r[b_r] ? (WIDTH+2)'(x_r) : '0);

  always_comb begin
    priority if (t >= m2) begin
      t_red = t - m2;
    end else if (t >= m1) begin
      t_red = t - m1;
    end else begin
      t_red = t;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r <= WIDTH'(in_order_prime);
      m_r <= WIDTH'(in_modulus);
    end
    if (cmd.cand_init) begin
      c_r <= WIDTH'(2);
      r_r <= r_init;
      x_r <= r_init;
      k_r <= WIDTH'(1);
    end
    if (cmd.cand_next) begin
      c_r <= c_r + WIDTH'(1);
      r_r <= r_next;
      x_r <= r_next;
      k_r <= WIDTH'(1);
    end
    if (cmd.mul_start) begin
      acc_r <= '0;
      b_r   <= BW'(WIDTH - 1);
    end
    if (cmd.mul_step) begin
      acc_r <= t_red[WIDTH-1:0];
      b_r   <= b_r - BW'(1);
      if (b_r == '0) begin
        x_r <= t_red[WIDTH-1:0];
        k_r <= k_r + WIDTH'(1);
      end
    end
    if (cmd.out_load) begin
      root_r  <= cmd.out_found ? FIELD_W'(c_r) : FIELD_W'(1);
      found_r <= cmd.out_found;
    end
  end

  assign status.trivial  = (p_r <= WIDTH'(2)) || (m_r <= WIDTH'(1));
  assign status.bit_last = (b_r == '0);
  assign status.x_is_one = (x_r == WIDTH'(1));
  assign status.k_at_n   = (k_r == (p_r - WIDTH'(1)));
  assign status.c_last   = ((c_r + WIDTH'(1)) == p_r);

  assign out_root  = root_r;
  assign out_found = found_r;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  typedef struct {
    logic [15:0] order_prime;
    logic [15:0] modulus;
    bit          steady;
  } search_req_t;

  typedef struct {
    logic [15:0] root;
    logic        found;
  } root_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_order_prime = '0;
  logic [15:0] in_modulus = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_root;
  logic        out_found;

  search_req_t  pending_reqs[$];
  root_result_t expected_roots[$];
  search_req_t  next_req;
  root_result_t got_exp;

  // While set, neither side inserts idle cycles.
  bit steady = 1'b0;

  int          errors = 0;
  int          beats_sent = 0;
  int          roots_found = 0;
  int          results_checked = 0;
  longint      cycles = 0;
  longint      cycle_limit = 64'd1_000_000_000;

  primitive_root_search dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_order_prime (in_order_prime),
    .in_modulus     (in_modulus),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_root       (out_root),
    .out_found      (out_found)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Walks the power chain of each candidate: the first power is compared
  // unreduced, later powers are reduced mod m, and the chain stops at the
  // first power equal to one.
  function automatic root_result_t smallest_primitive_root(input logic [15:0] p,
                                                           input logic [15:0] m);
    root_result_t    res;
    longint unsigned pw;
    int unsigned     c;
    int unsigned     k;
    bit              ok;
    res.root = 16'd1;
    res.found = 1'b0;
    if (p <= 2 || m <= 1) return res;
    for (c = 2; c < p; c++) begin
      pw = c;
      ok = 1'b0;
      for (k = 1; k < p; k++) begin
        if (k > 1) pw = (pw * c) % m;
        if (k == p - 1) begin
          ok = ((pw % m) == 1);
        end else if (pw == 1) begin
          break;
        end
      end
      if (ok) begin
        res.root = c[15:0];
        res.found = 1'b1;
        return res;
      end
    end
    return res;
  endfunction

  // Driver: one request beat at a time from the pending queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        got_exp = smallest_primitive_root(in_order_prime, in_modulus);
        expected_roots.push_back(got_exp);
        beats_sent++;
        if (got_exp.found) roots_found++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
          next_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_order_prime <= next_req.order_prime;
          in_modulus <= next_req.modulus;
          steady <= next_req.steady;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and in-order comparison of result beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 28);
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_roots.size() == 0) begin
          $display("%0t: unexpected result beat, root %0d found %0b", $time, out_root,
                   out_found);
          errors++;
        end else begin
          got_exp = expected_roots.pop_front();
          if (out_root !== got_exp.root) begin
            $display("%0t: root mismatch, expected %0d, actual %0d", $time, got_exp.root,
                     out_root);
            errors++;
          end
          if (out_found !== got_exp.found) begin
            $display("%0t: found mismatch, expected %0b, actual %0b", $time, got_exp.found,
                     out_found);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > cycle_limit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("[primitive_root_search] ERROR");
      $finish;
    end
  end

  task automatic add_search(input logic [15:0] p, input logic [15:0] m, input bit calm,
                            inout longint budget);
    search_req_t req;
    req.order_prime = p;
    req.modulus = m;
    req.steady = calm;
    pending_reqs.push_back(req);
    // Worst case: every candidate runs its whole chain, plus room for stalls.
    if (p > 2 && m > 1) budget += longint'(p - 2) * longint'(p - 2) * 18 + 4;
    budget += 400;
  endtask

  initial begin
    int     prime_list[22];
    int     i;
    int     pick;
    int     p;
    int     m;
    longint budget;
    prime_list = '{29, 31, 37, 41, 43, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97,
                   101, 103, 107, 109, 113, 127, 131};
    budget = 0;

    // Trivial requests that answer at once, with the field extremes.
    add_search(16'd0, 16'd65535, 1'b0, budget);
    add_search(16'd1, 16'd1, 1'b0, budget);
    add_search(16'd2, 16'd65535, 1'b0, budget);
    add_search(16'd65535, 16'd1, 1'b0, budget);
    add_search(16'd65535, 16'd0, 1'b0, budget);
    // Smallest real searches, one with no unit candidate.
    add_search(16'd3, 16'd2, 1'b0, budget);
    add_search(16'd3, 16'd3, 1'b0, budget);
    add_search(16'd3, 16'd65535, 1'b0, budget);
    add_search(16'd4, 16'd65535, 1'b0, budget);
    add_search(16'd9, 16'd65535, 1'b0, budget);
    // Prime moduli where a true primitive root exists.
    add_search(16'd5, 16'd5, 1'b0, budget);
    add_search(16'd7, 16'd7, 1'b0, budget);
    add_search(16'd11, 16'd11, 1'b0, budget);
    add_search(16'd13, 16'd13, 1'b0, budget);
    add_search(16'd17, 16'd17, 1'b0, budget);
    add_search(16'd251, 16'd251, 1'b0, budget);
    add_search(16'd257, 16'd257, 1'b0, budget);
    // Candidates at or above the modulus, including ones congruent to one.
    add_search(16'd7, 16'd3, 1'b0, budget);
    add_search(16'd10, 16'd3, 1'b0, budget);
    add_search(16'd23, 16'd5, 1'b0, budget);
    // Order p-1 impossible for the modulus.
    add_search(16'd23, 16'd47, 1'b0, budget);
    add_search(16'd10, 16'd11, 1'b0, budget);

    for (i = 0; i < 100; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        p = $urandom_range(32, 3);
        m = $urandom_range(64, 2);
      end else if (pick < 80) begin
        p = $urandom_range(24, 3);
        m = $urandom_range(65535, 2);
      end else if (pick < 84) begin
        p = $urandom_range(2, 0);
        m = $urandom_range(65535, 1);
      end else if (pick < 88) begin
        p = $urandom_range(65535, 0);
        m = $urandom_range(1, 0);
      end else if (pick < 95) begin
        p = prime_list[$urandom_range(21)];
        m = p;
      end else begin
        p = $urandom_range(40, 3);
        m = prime_list[$urandom_range(14)];
      end
      add_search(p[15:0], m[15:0], (i >= 40 && i < 60), budget);
    end
    cycle_limit = 4 * budget + 20000;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    forever begin
      @(posedge clk);
      if (pending_reqs.size() == 0 && !in_valid && expected_roots.size() == 0) break;
    end
    repeat (50) @(posedge clk);

    $display("Sent %0d search requests, %0d of them with a primitive root expected.",
             beats_sent, roots_found);
    $display("Checked %0d result beats under random stalls on both channels.",
             results_checked);
    if (errors == 0 && expected_roots.size() == 0) begin
      $display("[primitive_root_search] OK");
    end else begin
      $display("[primitive_root_search] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/prs_pkg.sv
rtl/prs_ctrl.sv
rtl/prs_datapath.sv
rtl/primitive_root_search.sv
tb/tb.sv
